@@ rtl/sit_pkg.sv @@
// shared types, codes and defaults for the sorted interval table
`timescale 1ns / 1ps

package sit_pkg;

   // default sizes
   localparam int SIT_ENTRIES   = 64;
   localparam int SIT_ADDR_BITS = 20;
   localparam int SIT_ID_BITS   = 16;

   // fixed result field widths
   localparam int SIT_STATUS_W = 2;
   localparam int SIT_INDEX_W  = 6;
   localparam int SIT_CMD_W    = 2;

   // command codes
   localparam logic [SIT_CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [SIT_CMD_W-1:0] CMD_CONTAIN = 2'd1;
   localparam logic [SIT_CMD_W-1:0] CMD_LOWER   = 2'd2;
   localparam logic [SIT_CMD_W-1:0] CMD_SPARE   = 2'd3;

   // status codes
   localparam logic [SIT_STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [SIT_STATUS_W-1:0] ST_REJECT = 2'd1;
   localparam logic [SIT_STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [SIT_STATUS_W-1:0] ST_NONE   = 2'd3;

   // per-cell compare results against the captured query
   typedef struct packed {
      logic gt;      // cell start above query address
      logic eq;      // cell start equals query address
      logic hit;     // end known and query address below cell end
      logic lt_end;  // cell start below the insert end
   } sit_flag_type;

   // commands broadcast from the controller to every cell
   typedef struct packed {
      logic capture; // latch compare flags from the request ports
      logic insert;  // shift up above the insert point, load new entry there
   } sit_cell_ctl_type;

endpackage

@@ rtl/sit_cell.sv @@
// one table entry: storage, compare flags and shift from the lower neighbor
`timescale 1ns / 1ps

module sit_cell #(
   parameter int ENTRIES   = sit_pkg::SIT_ENTRIES,
   parameter int ADDR_BITS = sit_pkg::SIT_ADDR_BITS,
   parameter int ID_BITS   = sit_pkg::SIT_ID_BITS,
   parameter int INDEX     = 0
) (
   input  logic                        clock,
   input  sit_pkg::sit_cell_ctl_type   ctl,
   input  logic [$clog2(ENTRIES)-1:0]  ins_pos,
   input  logic [ADDR_BITS-1:0]        cmp_addr,
   input  logic [ADDR_BITS-1:0]        cmp_end,
   input  logic [ADDR_BITS-1:0]        new_start,
   input  logic [ADDR_BITS-1:0]        new_end,
   input  logic                        new_known,
   input  logic [ID_BITS-1:0]          new_id,
   input  logic [ADDR_BITS-1:0]        left_start,
   input  logic [ADDR_BITS-1:0]        left_end,
   input  logic                        left_known,
   input  logic [ID_BITS-1:0]          left_id,
   output logic [ADDR_BITS-1:0]        cell_start,
   output logic [ADDR_BITS-1:0]        cell_end,
   output logic                        cell_known,
   output logic [ID_BITS-1:0]          cell_id,
   output sit_pkg::sit_flag_type       cell_flags
);
   import sit_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS-1:0] end_ff, end_in;
   logic                 known_ff, known_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   sit_flag_type         flags_ff, flags_in;

   // entry update: new entry at the insert point, neighbor above it
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      known_in = known_ff;
      id_in    = id_ff;
      if (ctl.insert) begin
         if (MY_IDX == ins_pos) begin
            start_in = new_start;
            end_in   = new_end;
            known_in = new_known;
            id_in    = new_id;
         end else if (MY_IDX > ins_pos) begin
            start_in = left_start;
            end_in   = left_end;
            known_in = left_known;
            id_in    = left_id;
         end
      end
   end

   // compare flags against the incoming request
   always_comb begin
      flags_in = flags_ff;
      if (ctl.capture) begin
         flags_in.gt     = start_ff > cmp_addr;
         flags_in.eq     = start_ff == cmp_addr;
         flags_in.hit    = known_ff && (cmp_addr < end_ff);
         flags_in.lt_end = start_ff < cmp_end;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      known_ff <= known_in;
      id_ff    <= id_in;
      flags_ff <= flags_in;
   end

   assign cell_start = start_ff;
   assign cell_end   = end_ff;
   assign cell_known = known_ff;
   assign cell_id    = id_ff;
   assign cell_flags = flags_ff;

endmodule

@@ rtl/sit_ctrl.sv @@
// request handshake, binary search over cell flags, result register
`timescale 1ns / 1ps

module sit_ctrl #(
   parameter int ENTRIES   = sit_pkg::SIT_ENTRIES,
   parameter int ADDR_BITS = sit_pkg::SIT_ADDR_BITS,
   parameter int ID_BITS   = sit_pkg::SIT_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sit_pkg::SIT_CMD_W-1:0]     req_command,
   input  logic [ADDR_BITS-1:0]              req_address,
   input  logic [ADDR_BITS-1:0]              req_end_address,
   input  logic                              req_end_is_known,
   input  logic [ID_BITS-1:0]                req_block_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sit_pkg::SIT_STATUS_W-1:0]  rsp_status,
   output logic [sit_pkg::SIT_INDEX_W-1:0]   rsp_entry_index,
   output logic [ADDR_BITS-1:0]              rsp_entry_start,
   output logic [ADDR_BITS-1:0]              rsp_entry_end,
   output logic                              rsp_entry_end_known,
   output logic [ID_BITS-1:0]                rsp_entry_id,
   input  sit_pkg::sit_flag_type             cell_flags [ENTRIES],
   input  logic [ADDR_BITS-1:0]              rd_start,
   input  logic [ADDR_BITS-1:0]              rd_end,
   input  logic                              rd_known,
   input  logic [ID_BITS-1:0]                rd_id,
   output logic [$clog2(ENTRIES)-1:0]        sel_idx,
   output sit_pkg::sit_cell_ctl_type         cell_ctl,
   output logic [ADDR_BITS-1:0]              new_start,
   output logic [ADDR_BITS-1:0]              new_end,
   output logic                              new_known,
   output logic [ID_BITS-1:0]                new_id
);
   import sit_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SRCH = 3'b010,
      S_SEL  = 3'b100
   } sit_state_type;

   sit_state_type state_ff, state_in;

   logic [SIT_CMD_W-1:0] cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] end_ff, end_in;
   logic                 known_ff, known_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     sel_ff, sel_in;
   logic                 exit_ff, exit_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SIT_STATUS_W-1:0] status_ff, status_in;
   logic [SIT_INDEX_W-1:0]  index_ff, index_in;
   logic [ADDR_BITS-1:0]    rstart_ff, rstart_in;
   logic [ADDR_BITS-1:0]    rend_ff, rend_in;
   logic                    rknown_ff, rknown_in;
   logic [ID_BITS-1:0]      rid_ff, rid_in;

   logic                 accept;
   logic                 slot_free;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid_cnt;
   logic [IDX_W-1:0]     mid;
   sit_flag_type         mid_flags;
   logic [CNT_W+5:0]     sel_ext;
   logic                 do_insert;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // midpoint of the current search window
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cnt   = mid_sum[CNT_W:1];
   assign mid       = mid_cnt[IDX_W-1:0];
   assign mid_flags = cell_flags[mid];

   assign sel_idx = sel_ff[IDX_W-1:0];
   assign sel_ext = (CNT_W + 6)'(sel_ff);

   // sequencer: capture, search one step a cycle, then select and deliver
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      known_in     = known_ff;
      id_in        = id_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sel_in       = sel_ff;
      exit_in      = exit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      index_in     = index_ff;
      rstart_in    = rstart_ff;
      rend_in      = rend_ff;
      rknown_in    = rknown_ff;
      rid_in       = rid_ff;
      do_insert    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               addr_in  = req_address;
               end_in   = req_end_address;
               known_in = req_end_is_known;
               id_in    = req_block_id;
               lo_in    = '0;
               hi_in    = count_ff;
               exit_in  = 1'b0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff >= hi_ff || cmd_ff == CMD_SPARE) begin
               sel_in   = (cmd_ff == CMD_CONTAIN) ? lo_ff - CNT_W'(1) : hi_ff;
               state_in = S_SEL;
            end else if (mid_flags.gt) begin
               hi_in = mid_cnt;
            end else if (mid_flags.eq ||
                         (cmd_ff == CMD_CONTAIN && mid_flags.hit)) begin
               exit_in  = 1'b1;
               sel_in   = mid_cnt;
               state_in = S_SEL;
            end else begin
               lo_in = mid_cnt + CNT_W'(1);
            end
         end
         S_SEL: begin
            if (slot_free) begin
               status_in    = ST_NONE;
               index_in     = '0;
               rstart_in    = '0;
               rend_in      = '0;
               rknown_in    = 1'b0;
               rid_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (cmd_ff)
                  CMD_INSERT: begin
                     index_in = sel_ext[SIT_INDEX_W-1:0];
                     if (exit_ff) begin
                        status_in = ST_REJECT;
                     end else if (sel_ff < count_ff && cell_flags[sel_idx].lt_end) begin
                        status_in = ST_REJECT;
                     end else if (count_ff == FULL_COUNT) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        rstart_in = addr_ff;
                        rend_in   = end_ff;
                        rknown_in = known_ff;
                        rid_in    = id_ff;
                        do_insert = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_CONTAIN, CMD_LOWER: begin
                     if (exit_ff ||
                         (cmd_ff == CMD_CONTAIN && lo_ff != '0) ||
                         (cmd_ff == CMD_LOWER && sel_ff < count_ff)) begin
                        status_in = ST_OK;
                        index_in  = sel_ext[SIT_INDEX_W-1:0];
                        rstart_in = rd_start;
                        rend_in   = rd_end;
                        rknown_in = rd_known;
                        rid_in    = rd_id;
                     end
                  end
                  default: begin
                     status_in = ST_NONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         exit_ff      <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         exit_ff      <= exit_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
      end
   end

   // query and result payload
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      end_ff    <= end_in;
      known_ff  <= known_in;
      id_ff     <= id_in;
      sel_ff    <= sel_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      rstart_ff <= rstart_in;
      rend_ff   <= rend_in;
      rknown_ff <= rknown_in;
      rid_ff    <= rid_in;
   end

   assign cell_ctl.capture = accept;
   assign cell_ctl.insert  = do_insert;
   assign new_start = addr_ff;
   assign new_end   = end_ff;
   assign new_known = known_ff;
   assign new_id    = id_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_entry_index     = index_ff;
   assign rsp_entry_start     = rstart_ff;
   assign rsp_entry_end       = rend_ff;
   assign rsp_entry_end_known = rknown_ff;
   assign rsp_entry_id        = rid_ff;

`ifndef SYNTHESIS
   // table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // an insert only happens with room left and bumps the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)) && ($past(count_ff) < FULL_COUNT))
      else $error("insert count update wrong");

   // search window stays well formed
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search window inverted");

   // a result beat appears only out of the select step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_SEL))
      else $error("result beat without select step");
`endif

endmodule

@@ rtl/sorted_interval_table_top.sv @@
// sorted interval table: controller plus a chain of entry cells
//
//  channel | direction | beat fields
//  req_    | in        | command, address, end_address, end_is_known, block_id
//  rsp_    | out       | status, entry_index, entry_start, entry_end,
//          |           | entry_end_known, entry_id
//
// one item at a time: accept cycle latches the query and every cell's compare
// flags, then one binary search step a cycle until a step finds a match or sees
// the window closed, then a select step that loads the result register and
// shifts the cells on insert.
// synchronous reset empties the table at once; no clearing pass.
// a stalled result holds the select step until the output register frees.
`timescale 1ns / 1ps

module sorted_interval_table_top #(
   parameter int ENTRIES   = sit_pkg::SIT_ENTRIES,
   parameter int ADDR_BITS = sit_pkg::SIT_ADDR_BITS,
   parameter int ID_BITS   = sit_pkg::SIT_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sit_pkg::SIT_CMD_W-1:0]     req_command,
   input  logic [ADDR_BITS-1:0]              req_address,
   input  logic [ADDR_BITS-1:0]              req_end_address,
   input  logic                              req_end_is_known,
   input  logic [ID_BITS-1:0]                req_block_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sit_pkg::SIT_STATUS_W-1:0]  rsp_status,
   output logic [sit_pkg::SIT_INDEX_W-1:0]   rsp_entry_index,
   output logic [ADDR_BITS-1:0]              rsp_entry_start,
   output logic [ADDR_BITS-1:0]              rsp_entry_end,
   output logic                              rsp_entry_end_known,
   output logic [ID_BITS-1:0]                rsp_entry_id
);
   import sit_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   sit_flag_type         cell_flags [ENTRIES];
   logic [ADDR_BITS-1:0] cell_start [ENTRIES];
   logic [ADDR_BITS-1:0] cell_end   [ENTRIES];
   logic                 cell_known [ENTRIES];
   logic [ID_BITS-1:0]   cell_id    [ENTRIES];

   sit_cell_ctl_type     cell_ctl;
   logic [IDX_W-1:0]     sel_idx;
   logic [ADDR_BITS-1:0] new_start, new_end;
   logic                 new_known;
   logic [ID_BITS-1:0]   new_id;
   logic [ADDR_BITS-1:0] rd_start, rd_end;
   logic                 rd_known;
   logic [ID_BITS-1:0]   rd_id;

   sit_ctrl #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS),
      .ID_BITS   (ID_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_address         (req_address),
      .req_end_address     (req_end_address),
      .req_end_is_known    (req_end_is_known),
      .req_block_id        (req_block_id),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_start     (rsp_entry_start),
      .rsp_entry_end       (rsp_entry_end),
      .rsp_entry_end_known (rsp_entry_end_known),
      .rsp_entry_id        (rsp_entry_id),
      .cell_flags          (cell_flags),
      .rd_start            (rd_start),
      .rd_end              (rd_end),
      .rd_known            (rd_known),
      .rd_id               (rd_id),
      .sel_idx             (sel_idx),
      .cell_ctl            (cell_ctl),
      .new_start           (new_start),
      .new_end             (new_end),
      .new_known           (new_known),
      .new_id              (new_id)
   );

   // chain of cells, each fed by its lower neighbor
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [ADDR_BITS-1:0] left_start, left_end;
      logic                 left_known;
      logic [ID_BITS-1:0]   left_id;

      if (i == 0) begin : g_first
         assign left_start = '0;
         assign left_end   = '0;
         assign left_known = 1'b0;
         assign left_id    = '0;
      end else begin : g_rest
         assign left_start = cell_start[i-1];
         assign left_end   = cell_end[i-1];
         assign left_known = cell_known[i-1];
         assign left_id    = cell_id[i-1];
      end

      sit_cell #(
         .ENTRIES   (ENTRIES),
         .ADDR_BITS (ADDR_BITS),
         .ID_BITS   (ID_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .ins_pos    (sel_idx),
         .cmp_addr   (req_address),
         .cmp_end    (req_end_address),
         .new_start  (new_start),
         .new_end    (new_end),
         .new_known  (new_known),
         .new_id     (new_id),
         .left_start (left_start),
         .left_end   (left_end),
         .left_known (left_known),
         .left_id    (left_id),
         .cell_start (cell_start[i]),
         .cell_end   (cell_end[i]),
         .cell_known (cell_known[i]),
         .cell_id    (cell_id[i]),
         .cell_flags (cell_flags[i])
      );
   end

   // read bus: the selected cell drives an and-or tree
   always_comb begin
      rd_start = '0;
      rd_end   = '0;
      rd_known = 1'b0;
      rd_id    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel_idx == IDX_W'(i)) begin
            rd_start = rd_start | cell_start[i];
            rd_end   = rd_end | cell_end[i];
            rd_known = rd_known | cell_known[i];
            rd_id    = rd_id | cell_id[i];
         end
      end
   end

endmodule

@@ dv/tb_top.sv @@
// testbench for the sorted interval table: directed rows, then random traffic
`timescale 1ns / 1ps

module tb_top;
   import sit_pkg::*;

   localparam int TBL_DEPTH = SIT_ENTRIES;
   localparam int AW        = SIT_ADDR_BITS;
   localparam int IW        = SIT_ID_BITS;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam logic [AW-1:0] MAX_ADDR = '1;

   // one request beat
   typedef struct packed {
      logic [SIT_CMD_W-1:0] command;
      logic [AW-1:0]        address;
      logic [AW-1:0]        end_address;
      logic                 end_is_known;
      logic [IW-1:0]        block_id;
   } req_beat_type;

   // one response beat
   typedef struct packed {
      logic [SIT_STATUS_W-1:0] status;
      logic [SIT_INDEX_W-1:0]  index;
      logic [AW-1:0]           start_addr;
      logic [AW-1:0]           end_addr;
      logic                    end_known;
      logic [IW-1:0]           id;
   } lookup_result_type;

   localparam lookup_result_type EMPTY_RESULT = {ST_NONE, 63'd0};

   // directed row: beat plus an optional hand-written answer
   typedef struct {
      req_beat_type      beat;
      bit                typed;
      lookup_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SIT_CMD_W-1:0] req_command = CMD_INSERT;
   logic [AW-1:0] req_address = '0;
   logic [AW-1:0] req_end_address = '0;
   logic req_end_is_known = 1'b0;
   logic [IW-1:0] req_block_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SIT_STATUS_W-1:0] rsp_status;
   logic [SIT_INDEX_W-1:0] rsp_entry_index;
   logic [AW-1:0] rsp_entry_start;
   logic [AW-1:0] rsp_entry_end;
   logic rsp_entry_end_known;
   logic [IW-1:0] rsp_entry_id;

   // shadow copy of the table
   logic [AW-1:0] tbl_start [TBL_DEPTH];
   logic [AW-1:0] tbl_end   [TBL_DEPTH];
   logic          tbl_known [TBL_DEPTH];
   logic [IW-1:0] tbl_id    [TBL_DEPTH];
   int            tbl_count = 0;

   lookup_result_type pending_results[$];
   directed_row_type  directed_rows[$];

   int beats_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int sender_quiet = 0;
   int n_stored = 0, n_rejected = 0, n_full = 0, n_found = 0, n_not_found = 0;

   sorted_interval_table_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_address         (req_address),
      .req_end_address     (req_end_address),
      .req_end_is_known    (req_end_is_known),
      .req_block_id        (req_block_id),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_start     (rsp_entry_start),
      .rsp_entry_end       (rsp_entry_end),
      .rsp_entry_end_known (rsp_entry_end_known),
      .rsp_entry_id        (rsp_entry_id)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 94) return $urandom_range(1, 4);
      return $urandom_range(15, 70);
   endfunction

   // build a result, pulling entry fields from the shadow table when asked
   function automatic lookup_result_type entry_result(logic [SIT_STATUS_W-1:0] st, int pos,
                                                      bit with_entry);
      lookup_result_type r;
      r = '0;
      r.status = st;
      r.index = pos[SIT_INDEX_W-1:0];
      if (with_entry && pos < TBL_DEPTH) begin
         r.start_addr = tbl_start[pos];
         r.end_addr = tbl_end[pos];
         r.end_known = tbl_known[pos];
         r.id = tbl_id[pos];
      end
      return r;
   endfunction

   // apply one command to the shadow table and return its answer
   function automatic lookup_result_type table_apply(req_beat_type b);
      int lo, hi, mid, i;
      lo = 0;
      hi = tbl_count;
      case (b.command)
         CMD_INSERT: begin
            while (hi > lo) begin
               mid = (lo + hi) / 2;
               if (tbl_start[mid] < b.address) lo = mid + 1;
               else if (tbl_start[mid] > b.address) hi = mid;
               else return entry_result(ST_REJECT, mid, 1'b0);
            end
            // only the following entry is checked for overlap
            if (hi < tbl_count && tbl_start[hi] < b.end_address)
               return entry_result(ST_REJECT, hi, 1'b0);
            if (tbl_count >= TBL_DEPTH) return entry_result(ST_FULL, hi, 1'b0);
            for (i = tbl_count; i > hi; i--) begin
               tbl_start[i] = tbl_start[i-1];
               tbl_end[i] = tbl_end[i-1];
               tbl_known[i] = tbl_known[i-1];
               tbl_id[i] = tbl_id[i-1];
            end
            tbl_start[hi] = b.address;
            tbl_end[hi] = b.end_address;
            tbl_known[hi] = b.end_is_known;
            tbl_id[hi] = b.block_id;
            tbl_count++;
            return entry_result(ST_OK, hi, 1'b1);
         end
         CMD_CONTAIN: begin
            // search with early exits, falls back to the predecessor
            while (hi > lo) begin
               mid = (lo + hi) / 2;
               if (tbl_start[mid] > b.address) hi = mid;
               else if (tbl_start[mid] == b.address) return entry_result(ST_OK, mid, 1'b1);
               else if (tbl_known[mid] && b.address < tbl_end[mid])
                  return entry_result(ST_OK, mid, 1'b1);
               else lo = mid + 1;
            end
            if (lo == 0) return EMPTY_RESULT;
            return entry_result(ST_OK, lo - 1, 1'b1);
         end
         CMD_LOWER: begin
            while (hi > lo) begin
               mid = (lo + hi) / 2;
               if (tbl_start[mid] > b.address) hi = mid;
               else if (tbl_start[mid] == b.address) return entry_result(ST_OK, mid, 1'b1);
               else lo = mid + 1;
            end
            if (hi < tbl_count) return entry_result(ST_OK, hi, 1'b1);
            return EMPTY_RESULT;
         end
         default: begin
            return EMPTY_RESULT;
         end
      endcase
   endfunction

   function automatic void add_row(logic [SIT_CMD_W-1:0] cmd, logic [AW-1:0] addr,
                                   logic [AW-1:0] end_addr, logic known, logic [IW-1:0] id,
                                   bit typed, lookup_result_type want);
      directed_row_type row;
      row.beat = {cmd, addr, end_addr, known, id};
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void report_mismatch(string what, longint unsigned exp_v,
                                           longint unsigned got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s at result %0d: expected %0h, got %0h",
                  what, results_seen, exp_v, got_v);
   endfunction

   // drive one beat after a random gap, record its expected answer on acceptance
   task automatic offer_beat(input req_beat_type b, input bit typed,
                             input lookup_result_type hand);
      int g;
      lookup_result_type want;
      if (sender_quiet > 0) begin
         sender_quiet--;
         g = 0;
      end else begin
         g = idle_len();
         if ($urandom_range(0, 49) == 0) sender_quiet = 40;
      end
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= b.command;
      req_address <= b.address;
      req_end_address <= b.end_address;
      req_end_is_known <= b.end_is_known;
      req_block_id <= b.block_id;
      // ready seen mid-cycle means the beat goes in at the next edge
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      want = table_apply(b);
      if (typed) want = hand;
      pending_results.push_back(want);
      if (b.command == CMD_INSERT) begin
         if (want.status == ST_OK) n_stored++;
         else if (want.status == ST_REJECT) n_rejected++;
         else n_full++;
      end else if (want.status == ST_OK) n_found++;
      else n_not_found++;
      beats_sent++;
      @(posedge clock);
   endtask

   // response checker, sampled mid-cycle
   always @(negedge clock) begin : rsp_check
      lookup_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", 0, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", want.status, rsp_status);
            if (rsp_entry_index !== want.index)
               report_mismatch("entry_index", want.index, rsp_entry_index);
            if (rsp_entry_start !== want.start_addr)
               report_mismatch("entry_start", want.start_addr, rsp_entry_start);
            if (rsp_entry_end !== want.end_addr)
               report_mismatch("entry_end", want.end_addr, rsp_entry_end);
            if (rsp_entry_end_known !== want.end_known)
               report_mismatch("entry_end_known", want.end_known, rsp_entry_end_known);
            if (rsp_entry_id !== want.id) report_mismatch("entry_id", want.id, rsp_entry_id);
         end
      end
   end

   // response side: random stalls, quiet stretches, one long hold-off
   initial begin : result_sink
      int stall_left;
      int quiet_cycles;
      bit held_off;
      stall_left = 0;
      quiet_cycles = 0;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && results_seen >= 600) begin
            held_off = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (quiet_cycles > 0) quiet_cycles--;
            else if ($urandom_range(0, 99) == 0) quiet_cycles = 200;
            else stall_left = idle_len();
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout: no beat for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, pending_results.size());
      $display("TB_ERROR");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      req_beat_type b;
      int roll, kind, j, e, n_directed;
      logic [AW-1:0] base_s, base_e;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table, spare command
      add_row(CMD_CONTAIN, 20'h00000, 20'h00000, 1'b0, 16'h0000, 1'b1, EMPTY_RESULT);
      add_row(CMD_LOWER, 20'hFFFFF, 20'hFFFFF, 1'b1, 16'hFFFF, 1'b1, EMPTY_RESULT);
      add_row(CMD_SPARE, 20'hFFFFF, 20'hFFFFF, 1'b1, 16'hFFFF, 1'b1, EMPTY_RESULT);
      // first entry at address zero, then a duplicate start
      add_row(CMD_INSERT, 20'h00000, 20'h00010, 1'b1, 16'hFFFF, 1'b1,
              {ST_OK, 6'd0, 20'h00000, 20'h00010, 1'b1, 16'hFFFF});
      add_row(CMD_INSERT, 20'h00000, 20'h00005, 1'b0, 16'h0001, 1'b1,
              {ST_REJECT, 6'd0, 20'h00000, 20'h00000, 1'b0, 16'h0000});
      add_row(CMD_INSERT, 20'hFFFFE, 20'hFFFFF, 1'b0, 16'h0000, 1'b1,
              {ST_OK, 6'd1, 20'hFFFFE, 20'hFFFFF, 1'b0, 16'h0000});
      add_row(CMD_INSERT, 20'h80000, 20'h90000, 1'b1, 16'h1234, 1'b0, '0);
      // overlap with the next entry, with known and unknown end
      add_row(CMD_INSERT, 20'h7F000, 20'h80001, 1'b1, 16'h5555, 1'b1,
              {ST_REJECT, 6'd1, 20'h00000, 20'h00000, 1'b0, 16'h0000});
      add_row(CMD_INSERT, 20'h7F000, 20'h80001, 1'b0, 16'hAAAA, 1'b1,
              {ST_REJECT, 6'd1, 20'h00000, 20'h00000, 1'b0, 16'h0000});
      // end touching the next start is fine
      add_row(CMD_INSERT, 20'h7F000, 20'h80000, 1'b0, 16'h00AA, 1'b0, '0);
      // inside the previous interval: not checked
      add_row(CMD_INSERT, 20'h00008, 20'h00009, 1'b1, 16'h0005, 1'b0, '0);
      // end below start
      add_row(CMD_INSERT, 20'h40000, 20'h00000, 1'b1, 16'h8001, 1'b0, '0);
      // containment: exact start, inside, unknown end, past all, at an end
      add_row(CMD_CONTAIN, 20'h80000, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_CONTAIN, 20'h85000, 20'hFFFFF, 1'b1, 16'hFFFF, 1'b0, '0);
      add_row(CMD_CONTAIN, 20'h7F800, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_CONTAIN, 20'hFFFFF, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_CONTAIN, 20'h00009, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_CONTAIN, 20'h00000, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      // lower bound
      add_row(CMD_LOWER, 20'h00000, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_LOWER, 20'h00001, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_LOWER, 20'h7F001, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_LOWER, 20'hFFFFE, 20'h00000, 1'b0, 16'h0000, 1'b0, '0);
      add_row(CMD_LOWER, 20'hFFFFF, 20'h00000, 1'b0, 16'h0000, 1'b1, EMPTY_RESULT);
      add_row(CMD_SPARE, 20'h00000, 20'h00000, 1'b0, 16'h0000, 1'b1, EMPTY_RESULT);

      foreach (directed_rows[i])
         offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      n_directed = beats_sent;

      // random traffic: the table fills slowly, then stays full
      while (beats_sent < RANDOM_ITEMS) begin
         b.command = CMD_CONTAIN;
         b.address = AW'($urandom_range(0, MAX_ADDR));
         b.end_address = AW'($urandom);
         b.end_is_known = 1'($urandom);
         b.block_id = IW'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < ((tbl_count < TBL_DEPTH) ? 25 : 30)) begin
            b.command = CMD_INSERT;
            kind = $urandom_range(0, 9);
            if (tbl_count == TBL_DEPTH && $urandom_range(0, 3) == 0) begin
               // above every start while full: would-be position past the end
               b.address = MAX_ADDR;
            end else if (kind <= 5) begin
               b.address = AW'($urandom_range(0, MAX_ADDR - 2));
               e = int'(b.address) + int'($urandom_range(1, 4096));
               b.end_address = (e > int'(MAX_ADDR)) ? MAX_ADDR : AW'(e);
               if ($urandom_range(0, 7) == 0) b.end_address = AW'($urandom);
            end else if (kind <= 7 && tbl_count > 0) begin
               b.address = tbl_start[$urandom_range(0, tbl_count - 1)];
            end else if (kind == 8 && tbl_count > 0) begin
               j = $urandom_range(0, tbl_count - 1);
               b.address = tbl_start[j] - AW'($urandom_range(1, 256));
               b.end_address = tbl_start[j] + AW'($urandom_range(0, 100));
            end
            // keep the top address free until the table is full
            if (b.address == MAX_ADDR && tbl_count < TBL_DEPTH)
               b.address = MAX_ADDR - AW'(2);
         end else if (roll < 92) begin
            b.command = (roll < 75) ? CMD_CONTAIN : CMD_LOWER;
            if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
               j = $urandom_range(0, tbl_count - 1);
               base_s = tbl_start[j];
               base_e = tbl_end[j];
               case ($urandom_range(0, 4))
                  0: b.address = base_s;
                  1: b.address = base_s + AW'($urandom_range(1, 64));
                  2: b.address = base_e - AW'(1);
                  3: b.address = base_e;
                  default: b.address = base_s - AW'(1);
               endcase
            end
         end else begin
            b.command = CMD_SPARE;
         end
         offer_beat(b, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests (%0d directed), %0d responses checked, table at %0d of %0d",
               beats_sent, n_directed, results_seen, tbl_count, TBL_DEPTH);
      $display("inserts: %0d stored, %0d rejected, %0d full; lookups: %0d hit, %0d empty",
               n_stored, n_rejected, n_full, n_found, n_not_found);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
